/* rtl/core/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Types and character constants shared by the string escape decoder modules.
// ----------------------------------------------------------------------------
package sed_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } sed_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } sed_out_t;

  // one queued job: a literal byte, or a code point to expand as utf-8
  typedef struct packed {
    logic        is_code;
    logic [31:0] value;
    logic        last;
  } sed_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sed_q_status_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CTL_TAB      = 8'h09;
  localparam logic [7:0] CTL_BS       = 8'h08;
  localparam logic [7:0] CTL_CR       = 8'h0D;
  localparam logic [7:0] CTL_LF       = 8'h0A;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [5:0] UTF8_MASK  = 6'h3F;

  localparam logic [31:0] DIGIT_BIAS = 32'd55;

endpackage

/* rtl/core/string_escape_decoder_top.sv */
// path: a result item is held in the job queue, then in the back end's output register
// throughput: one input item per cycle while in_stall is low; one output byte per cycle from the back
//   end while out_stall is low, so a \u escape giving three utf-8 bytes holds the output until all three are sent
// the job queue (QUEUE_DEPTH entries) absorbs bursts; in_stall rises when it is full
// reset: synchronous, active low; clears escape state, empties the queue and output
// ----------------------------------------------------------------------------
// string_escape_decoder_top
// Backslash and \u unescaper for string literal bytes, front/queue/back split.
// ----------------------------------------------------------------------------
module string_escape_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sed_pkg::sed_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sed_pkg::sed_out_t out_data
);

  sed_pkg::sed_q_status_t q_status;
  sed_pkg::sed_entry_t    push_entry;
  sed_pkg::sed_entry_t    head;
  logic                   push_valid;
  logic                   pop;

  sed_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  sed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  sed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // front never offers a job the queue cannot take
  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !(push_valid && q_status.full))
    else $error("job pushed into full queue");

  // back only retires a job that is present
  a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_status.empty))
    else $error("job popped from empty queue");

  // end of string always closes the item's run of results
  a_done_closes_run : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_done |-> out_data.run_last)
    else $error("string_done without run_last");

endmodule

/* rtl/core/sed_front.sv */
// ----------------------------------------------------------------------------
// sed_front
// Accepts input bytes, tracks escape state, gathers \u digits and queues jobs.
// ----------------------------------------------------------------------------
module sed_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  sed_pkg::sed_in_t      in_data,
  output logic                  in_stall,
  input  sed_pkg::sed_q_status_t q_status,
  output logic                  push_valid,
  output sed_pkg::sed_entry_t   push_entry
);

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic [31:0] accum_r, accum_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [31:0] digit_val;
  logic [31:0] acc_sum;
  logic [7:0]  esc_byte;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign b        = in_data.in_byte;
  assign last     = in_data.in_last;

  always_comb begin
    if (b inside {[8'h30:8'h39]}) begin
      digit_val = {24'd0, b - 8'h30};
    end else if (b inside {[8'h61:8'h66]}) begin
      digit_val = {24'd0, b - 8'h57};
    end else begin
      // byte read as signed, less the letter bias, wrapping
      digit_val = {{24{b[7]}}, b} - sed_pkg::DIGIT_BIAS;
    end
  end

  assign acc_sum = {accum_r[27:0], 4'h0} + digit_val;

  always_comb begin
    case (b)
      sed_pkg::CH_T: esc_byte = sed_pkg::CTL_TAB;
      sed_pkg::CH_B: esc_byte = sed_pkg::CTL_BS;
      sed_pkg::CH_R: esc_byte = sed_pkg::CTL_CR;
      sed_pkg::CH_N: esc_byte = sed_pkg::CTL_LF;
      default:       esc_byte = b;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    accum_nxt  = accum_r;
    push_valid = 1'b0;
    push_entry = '{is_code: 1'b0, value: {24'd0, b}, last: last};
    if (accept) begin
      case (mode_r)
        MODE_ESCAPE: begin
          if (b == sed_pkg::CH_U) begin
            if (last) begin
              push_valid       = 1'b1;
              push_entry.value = '0;
              mode_nxt         = MODE_PLAIN;
            end else begin
              mode_nxt   = MODE_HEX;
              digits_nxt = '0;
              accum_nxt  = '0;
            end
          end else begin
            push_valid       = 1'b1;
            push_entry.value = {24'd0, esc_byte};
            mode_nxt         = MODE_PLAIN;
          end
        end
        MODE_HEX: begin
          if (digits_r == 2'd3 || last) begin
            push_valid         = 1'b1;
            push_entry.is_code = 1'b1;
            push_entry.value   = acc_sum;
            mode_nxt           = MODE_PLAIN;
            digits_nxt         = '0;
            accum_nxt          = '0;
          end else begin
            accum_nxt  = acc_sum;
            digits_nxt = digits_r + 2'd1;
          end
        end
        default: begin
          if (b == sed_pkg::CH_BACKSLASH && !last) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            push_valid = 1'b1;
            mode_nxt   = MODE_PLAIN;
          end
        end
      endcase
      if (last) begin
        mode_nxt   = MODE_PLAIN;
        digits_nxt = '0;
        accum_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PLAIN;
      digits_r <= '0;
      accum_r  <= '0;
    end else begin
      mode_r   <= mode_nxt;
      digits_r <= digits_nxt;
      accum_r  <= accum_nxt;
    end
  end

endmodule

/* rtl/core/sed_queue.sv */
// ----------------------------------------------------------------------------
// sed_queue
// Small job queue between the front and back halves of the decoder.
// ----------------------------------------------------------------------------
module sed_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  input  sed_pkg::sed_entry_t    push_entry,
  input  logic                   pop,
  output sed_pkg::sed_entry_t    head,
  output sed_pkg::sed_q_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sed_pkg::sed_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign status  = '{full: (count_r == CW'(DEPTH)), empty: (count_r == '0)};
  assign do_push = push_valid && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/core/sed_back.sv */
// ----------------------------------------------------------------------------
// sed_back
// Expands queued jobs into output bytes (utf-8 for code points), one a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module sed_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sed_pkg::sed_entry_t    head,
  input  sed_pkg::sed_q_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sed_pkg::sed_out_t      out_data
);

  logic              out_valid_r, out_valid_nxt;
  sed_pkg::sed_out_t out_data_r;
  logic [1:0]        idx_r, idx_nxt;
  logic [1:0]        n_bytes;
  logic [7:0]        cur_byte;
  logic              end_of_entry;
  logic              load;
  logic              take;
  logic [31:0]       cp;

  assign cp = head.value;

  always_comb begin
    if (!head.is_code || cp[31:7] == '0) begin
      n_bytes = 2'd1;
    end else if (cp[31:11] == '0) begin
      n_bytes = 2'd2;
    end else begin
      n_bytes = 2'd3;
    end
  end

  always_comb begin
    case (n_bytes)
      2'd2: begin
        if (idx_r == 2'd0) begin
          cur_byte = sed_pkg::UTF8_LEAD2 | cp[13:6];
        end else begin
          cur_byte = sed_pkg::UTF8_CONT | {2'b00, cp[5:0] & sed_pkg::UTF8_MASK};
        end
      end
      2'd3: begin
        case (idx_r)
          2'd0:    cur_byte = sed_pkg::UTF8_LEAD3 | cp[19:12];
          2'd1:    cur_byte = sed_pkg::UTF8_CONT | {2'b00, cp[11:6] & sed_pkg::UTF8_MASK};
          default: cur_byte = sed_pkg::UTF8_CONT | {2'b00, cp[5:0] & sed_pkg::UTF8_MASK};
        endcase
      end
      default: cur_byte = cp[7:0];
    endcase
  end

  assign end_of_entry = (idx_r == n_bytes - 2'd1);
  assign load         = !out_valid_r || !out_stall;
  assign take         = load && !q_status.empty;
  assign pop          = take && end_of_entry;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = !q_status.empty;
    end
    if (take) begin
      idx_nxt = end_of_entry ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.out_byte    <= cur_byte;
      out_data_r.run_last    <= end_of_entry;
      out_data_r.string_done <= end_of_entry && head.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
